// ----- hdl/periodic_timer_bank_macros.svh -----
// assertion helpers used by the timer bank datapath
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define PTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define PTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// types, codes and constants of the periodic timer bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [15:0] DELAY_CAP = 16'h8000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        F_TICK   = 2'd0,
        F_APPEND = 2'd1,
        F_DELETE = 2'd2,
        F_RSVD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        K_FIRE      = 2'd0,
        K_TICK_DONE = 2'd1,
        K_CMD_DONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_CMD_END,
        S_TICK_EVAL,
        S_TICK_DIV,
        S_TICK_FIRE,
        S_TICK_END
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] handle;
        logic [30:0] period;
        logic [31:0] payload;
        logic [30:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [15:0] fired_handle;
        logic [31:0] fired_payload;
        logic [15:0] fire_count;
        logic [15:0] next_delay;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic scan_free;
        logic apply_hit;
        logic apply_end;
        logic tick_skip;
        logic tick_keep;
        logic div_start;
        logic div_step;
        logic fire;
        logic tick_done;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic hit;
        logic idx_last;
        logic skip;
        logic tick_le0;
        logic div_last;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- hdl/ptb_datapath.sv -----
// ----------------------------------------------------------------------------
// ptb_datapath
// slot table, walk index, serial divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_timer_bank_macros.svh"

module ptb_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ptb_pkg::t_in_item     i_in_item,
    input  ptb_pkg::t_ctl_cmd     i_cmd,
    output ptb_pkg::t_dp_status   o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output ptb_pkg::t_out_item    o_out_item
);
    import ptb_pkg::*;

    logic              r_used [SLOTS];
    logic [15:0]       r_hdl  [SLOTS];
    logic [31:0]       r_pay  [SLOTS];
    logic [30:0]       r_per  [SLOTS];
    logic [31:0]       r_rem  [SLOTS];

    logic [1:0]        r_func;
    logic [15:0]       r_handle;
    logic [30:0]       r_period;
    logic [31:0]       r_payload;
    logic [30:0]       r_elapsed;

    logic [IDX_W-1:0]  r_idx;
    logic              r_free_v;
    logic [IDX_W-1:0]  r_free_idx;
    logic [15:0]       r_delay;

    logic [31:0]       r_div_q;
    logic [31:0]       r_div_m;
    logic [4:0]        r_div_cnt;

    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              cur_used;
    logic [15:0]       cur_hdl;
    logic [31:0]       cur_pay;
    logic [30:0]       cur_per;
    logic [31:0]       cur_rem;
    logic              cmd_ok;
    logic              idx_inc;
    logic [33:0]       tick_r;
    logic [33:0]       neg_r;
    logic [31:0]       fire_rem;
    logic [31:0]       rebase_rem;
    logic [15:0]       fire_cnt;
    logic [31:0]       dly_val;
    logic [15:0]       dly_next;
    logic [31:0]       div_t;
    logic [32:0]       div_d;
    logic              out_busy;
    logic              out_load;
    logic              out_is_fire;
    logic              out_is_close;

    always_comb begin
        cur_used   = r_used[r_idx];
        cur_hdl    = r_hdl[r_idx];
        cur_pay    = r_pay[r_idx];
        cur_per    = r_per[r_idx];
        cur_rem    = r_rem[r_idx];
        cmd_ok     = ((r_func == F_APPEND) || (r_func == F_DELETE)) && (r_handle != 16'd0);
        tick_r     = {{2{cur_rem[31]}}, cur_rem} - {3'b000, r_elapsed};
        neg_r      = 34'd0 - tick_r;
        fire_rem   = {1'b0, cur_per} - r_div_m;
        rebase_rem = cur_rem - {1'b0, cur_per} + {1'b0, r_period};
        fire_cnt   = (r_div_q >= 32'd65535) ? COUNT_MAX : (r_div_q[15:0] + 16'd1);
        dly_val    = i_cmd.fire ? fire_rem : tick_r[31:0];
        dly_next   = (dly_val < {16'd0, r_delay}) ? dly_val[15:0] : r_delay;
        div_t      = {r_div_m[30:0], r_div_q[31]};
        div_d      = {1'b0, div_t} - {2'b00, cur_per};
        idx_inc    = i_cmd.scan_free || i_cmd.tick_skip || i_cmd.tick_keep || i_cmd.fire;
        out_busy   = r_out_valid && i_out_stall;
        out_load   = i_cmd.apply_hit || i_cmd.apply_end || i_cmd.fire || i_cmd.tick_done;
        out_is_fire  = r_out_valid && (r_out.kind == K_FIRE);
        out_is_close = r_out_valid && (r_out.kind == K_TICK_DONE);
    end

    always_comb begin
        o_status.is_tick  = (r_func == F_TICK);
        o_status.hit      = cur_used && (cur_hdl == r_handle) && cmd_ok;
        o_status.idx_last = (r_idx == IDX_W'(SLOTS - 1));
        o_status.skip     = !cur_used || (cur_per == 31'd0);
        o_status.tick_le0 = tick_r[33] || (tick_r == 34'd0);
        o_status.div_last = (r_div_cnt == 5'd31);
        o_status.out_busy = out_busy;
    end

    // next result
    always_comb begin
        n_out        = '0;
        n_out.last   = 1'b1;
        n_out.kind   = K_CMD_DONE;
        n_out.status = ST_NOT_FOUND;
        if (i_cmd.apply_hit) begin
            n_out.slot   = 4'(r_idx);
            n_out.status = (r_func == F_DELETE) ? ST_REMOVED : ST_UPDATED;
        end else if (i_cmd.apply_end) begin
            if (cmd_ok && (r_func == F_APPEND)) begin
                n_out.status = r_free_v ? ST_ADDED : ST_FULL;
                n_out.slot   = r_free_v ? 4'(r_free_idx) : 4'd0;
            end
        end else if (i_cmd.fire) begin
            n_out.kind          = K_FIRE;
            n_out.slot          = 4'(r_idx);
            n_out.fired_handle  = cur_hdl;
            n_out.fired_payload = cur_pay;
            n_out.fire_count    = fire_cnt;
            n_out.status        = ST_UPDATED;
            n_out.last          = 1'b0;
        end else begin
            n_out.kind       = K_TICK_DONE;
            n_out.status     = ST_UPDATED;
            n_out.next_delay = r_delay;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_free_v    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOTS; k++) r_used[k] <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_idx    <= '0;
                r_free_v <= 1'b0;
            end else if (idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.scan_free && !cur_used && !r_free_v) r_free_v <= 1'b1;
            if (i_cmd.apply_hit && (r_func == F_DELETE)) r_used[r_idx] <= 1'b0;
            if (i_cmd.apply_end && cmd_ok && (r_func == F_APPEND) && r_free_v)
                r_used[r_free_idx] <= 1'b1;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func    <= i_in_item.func;
            r_handle  <= i_in_item.handle;
            r_period  <= i_in_item.period;
            r_payload <= i_in_item.payload;
            r_elapsed <= i_in_item.elapsed;
            r_delay   <= DELAY_CAP;
        end
        if (i_cmd.scan_free && !cur_used && !r_free_v) r_free_idx <= r_idx;
        if (i_cmd.apply_hit && (r_func == F_APPEND)) begin
            r_rem[r_idx] <= rebase_rem;
            r_pay[r_idx] <= r_payload;
            r_per[r_idx] <= r_period;
        end
        if (i_cmd.apply_end && cmd_ok && (r_func == F_APPEND) && r_free_v) begin
            r_hdl[r_free_idx] <= r_handle;
            r_pay[r_free_idx] <= r_payload;
            r_per[r_free_idx] <= r_period;
            r_rem[r_free_idx] <= {1'b0, r_period};
        end
        if (i_cmd.tick_keep) r_rem[r_idx] <= tick_r[31:0];
        if (i_cmd.fire)      r_rem[r_idx] <= fire_rem;
        if (i_cmd.tick_keep || i_cmd.fire) r_delay <= dly_next;
        // restoring divide of the overrun by the period, one quotient bit a cycle
        if (i_cmd.div_start) begin
            r_div_q   <= neg_r[31:0];
            r_div_m   <= 32'd0;
            r_div_cnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 5'd1;
            if (!div_d[32]) begin
                r_div_m <= div_d[31:0];
                r_div_q <= {r_div_q[30:0], 1'b1};
            end else begin
                r_div_m <= div_t;
                r_div_q <= {r_div_q[30:0], 1'b0};
            end
        end
        if (out_load) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `PTB_ASSERT_IMP(a_fire_count, out_is_fire, |r_out.fire_count && !r_out.last, "bad fire result")
    `PTB_ASSERT_IMP(a_close_last, out_is_close, r_out.last, "closing result without last")
    `PTB_ASSERT_IMP(a_close_delay, out_is_close, r_out.next_delay <= DELAY_CAP, "delay above cap")
    `PTB_ASSERT_NXT(a_div_start, i_cmd.div_start, r_div_cnt == 5'd0, "divider did not restart")

endmodule

// ----- hdl/ptb_controller.sv -----
// ----------------------------------------------------------------------------
// ptb_controller
// sequencer for table scans, tick walk and divider steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ptb_pkg::t_dp_status   i_status,
    output ptb_pkg::t_ctl_cmd     o_cmd
);
    import ptb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: n_state = i_status.is_tick ? S_TICK_EVAL : S_SCAN;
            S_SCAN: begin
                if (i_status.hit) begin
                    if (!i_status.out_busy) begin
                        o_cmd.apply_hit = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_free = 1'b1;
                    if (i_status.idx_last) n_state = S_CMD_END;
                end
            end
            S_CMD_END: begin
                if (!i_status.out_busy) begin
                    o_cmd.apply_end = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TICK_EVAL: begin
                if (i_status.skip) begin
                    o_cmd.tick_skip = 1'b1;
                    if (i_status.idx_last) n_state = S_TICK_END;
                end else if (!i_status.tick_le0) begin
                    o_cmd.tick_keep = 1'b1;
                    if (i_status.idx_last) n_state = S_TICK_END;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_TICK_DIV;
                end
            end
            S_TICK_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_TICK_FIRE;
            end
            S_TICK_FIRE: begin
                if (!i_status.out_busy) begin
                    o_cmd.fire = 1'b1;
                    n_state    = i_status.idx_last ? S_TICK_END : S_TICK_EVAL;
                end
            end
            S_TICK_END: begin
                if (!i_status.out_busy) begin
                    o_cmd.tick_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/periodic_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank
// table of sixteen periodic timers driven by append, delete and tick requests
// ----------------------------------------------------------------------------
// One request is taken at a time; o_in_stall stays high until its last result
// is loaded into the output register. Append and delete walk the slot table
// one slot a cycle; an update or delete stops at the matching slot. A tick
// walks all 16 slots one a cycle, except that for every slot that expires it
// runs a restoring divider on the overrun and then emits the fire result
// before it goes on. A result that waits on i_out_stall holds the walk only
// when another result is ready to be loaded behind it.
`timescale 1ns / 1ps

module periodic_timer_bank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ptb_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ptb_pkg::t_out_item   o_out_item
);
    import ptb_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // sequencer: scan, tick walk, divider stepping
    ptb_controller u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    // slot table, divider and result register
    ptb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (ctl_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
